/* rtl/fac_pkg.sv */
// Package: shared types, constants and tables of the follow-and-avoid controller.
`timescale 1ns / 1ps
package fac_pkg;

    localparam int MAX_RANGES   = 4096;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_TAB_LEN = 24;
    localparam int XW           = 27;
    localparam int ZW           = 24;
    localparam int STEP_W       = 5;
    localparam int HALF_PI_Q20  = 1647099;
    localparam int GAIN_Q16     = 39797;
    localparam int RECIP10_Q19  = 52429;
    localparam int RECIP12_Q16  = 5462;

    localparam logic [2:0] REG_RANGES_PER_SCAN = 3'd0;
    localparam logic [2:0] REG_OBST_THRESHOLD  = 3'd1;
    localparam logic [2:0] REG_STOP_DISTANCE   = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED       = 3'd3;
    localparam logic [2:0] REG_TURN_RATE       = 3'd4;
    localparam logic [2:0] REG_DEADBAND        = 3'd5;

    typedef struct packed {
        logic [12:0] ranges_per_scan;
        logic [15:0] obstacle_threshold_mm;
        logic [15:0] stop_distance_mm;
        logic [11:0] max_speed_mm_s;
        logic [11:0] turn_rate_mrad_s;
        logic [11:0] heading_deadband_mrad;
    } t_cfg;

    typedef struct packed {
        logic               avoid;
        logic               turn_neg;
        logic signed [23:0] x;
        logic signed [23:0] y;
    } t_cmd;

    function automatic logic [19:0] atan_q20(input logic [STEP_W-1:0] i);
        logic [19:0] v;
        case (i)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            5'd20:   v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/fac_in_if.sv */
// Interface: input item channel.
`timescale 1ns / 1ps
interface fac_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [11:0]        sample_index;
    logic [15:0]        range_mm;
    logic               range_valid;
    logic               leader_known;
    logic signed [23:0] leader_x_mm;
    logic signed [23:0] leader_y_mm;
    logic               random_bit;

    modport source (output valid, mode, sample_index, range_mm, range_valid, leader_known,
                    leader_x_mm, leader_y_mm, random_bit, input ready);
    modport sink (input valid, mode, sample_index, range_mm, range_valid, leader_known,
                  leader_x_mm, leader_y_mm, random_bit, output ready);
endinterface

/* rtl/fac_out_if.sv */
// Interface: result item channel.
`timescale 1ns / 1ps
interface fac_out_if;
    logic               valid;
    logic               ready;
    logic [11:0]        linear_speed_mm_s;
    logic signed [12:0] angular_rate_mrad_s;
    logic               avoiding;

    modport source (output valid, linear_speed_mm_s, angular_rate_mrad_s, avoiding,
                    input ready);
    modport sink (input valid, linear_speed_mm_s, angular_rate_mrad_s, avoiding,
                  output ready);
endinterface

/* rtl/fac_front.sv */
// Front end: accepts items, tracks the scan obstacle flag and turn state, queues commands.
`timescale 1ns / 1ps
module fac_front
    import fac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    fac_in_if.sink      i_item,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);
    logic        r_scan_hit, r_obstacle, r_turn_active, r_turn_neg;
    logic [12:0] n_eff, f_sec, n_minus_f;
    logic [28:0] f_prod;
    logic [12:0] idx;
    logic        accept, in_range, front, hit;

    always_comb begin
        n_eff     = (i_cfg.ranges_per_scan > 13'(MAX_RANGES)) ? 13'(MAX_RANGES)
                                                              : i_cfg.ranges_per_scan;
        f_prod    = 29'(n_eff) * 29'(RECIP12_Q16);
        f_sec     = f_prod[28:16];
        n_minus_f = n_eff - f_sec;
        idx       = {1'b0, i_item.sample_index};
        in_range  = idx < n_eff;
        front     = (idx <= f_sec) || (idx >= n_minus_f);
        hit       = i_item.range_valid && front
                    && (i_item.range_mm < i_cfg.obstacle_threshold_mm);
        accept    = i_item.valid && i_item.ready;
    end

    assign i_item.ready = !i_full;
    assign o_push       = accept && i_item.mode && (r_obstacle || i_item.leader_known);

    always_comb begin
        o_cmd.avoid    = r_obstacle;
        o_cmd.turn_neg = r_turn_active ? r_turn_neg : i_item.random_bit;
        o_cmd.x        = i_item.leader_x_mm;
        o_cmd.y        = i_item.leader_y_mm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_hit    <= 1'b0;
            r_obstacle    <= 1'b0;
            r_turn_active <= 1'b0;
            r_turn_neg    <= 1'b0;
        end else if (accept) begin
            if (!i_item.mode) begin
                if (in_range) begin
                    if (hit) begin
                        r_scan_hit <= 1'b1;
                    end else if (idx == 13'd0) begin
                        r_scan_hit <= 1'b0;
                    end
                    if (idx == n_eff - 13'd1) begin
                        r_obstacle <= hit || (r_scan_hit && idx != 13'd0);
                    end
                end
            end else if (r_obstacle) begin
                if (!r_turn_active) begin
                    r_turn_neg    <= i_item.random_bit;
                    r_turn_active <= 1'b1;
                end
            end else begin
                r_turn_active <= 1'b0;
            end
        end
    end
endmodule

/* rtl/fac_queue.sv */
// Two-entry command queue between front and back ends.
`timescale 1ns / 1ps
module fac_queue
    import fac_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count out of range");
endmodule

/* rtl/fac_back.sv */
// Back end: CORDIC polar conversion, steering and speed, result register.
`timescale 1ns / 1ps
module fac_back
    import fac_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_empty,
    input  t_cmd     i_cmd,
    output logic     o_pop,
    fac_out_if.source o_result
);
    typedef enum logic [2:0] {S_IDLE, S_ITER, S_MUL, S_POLAR, S_CMD} t_state;

    t_state                r_state;
    logic signed [XW-1:0]  r_x, r_y;
    logic signed [ZW-1:0]  r_z;
    logic [STEP_W-1:0]     r_i;
    logic                  r_origin;
    logic [42:0]           r_prod;
    logic [33:0]           r_zm;
    logic                  r_zneg;
    logic [25:0]           r_dist;
    logic [11:0]           r_ang;
    logic                  r_out_valid;
    logic [11:0]           r_speed;
    logic signed [12:0]    r_rate;
    logic                  r_avoid;

    logic signed [XW-1:0]  x0, y0, xs, ys;
    logic signed [ZW-1:0]  z0, zabs;
    logic [14:0]           sv;
    logic [30:0]           sprod;
    logic [31:0]           dprod;
    logic [15:0]           thr10;
    logic [11:0]           steer, speed;
    logic signed [12:0]    rate;
    logic [34:0]           zr;

    assign o_pop                     = (r_state == S_IDLE) && !r_out_valid && !i_empty;
    assign o_result.valid            = r_out_valid;
    assign o_result.linear_speed_mm_s   = r_speed;
    assign o_result.angular_rate_mrad_s = r_rate;
    assign o_result.avoiding         = r_avoid;

    always_comb begin
        x0 = XW'(i_cmd.x);
        y0 = XW'(i_cmd.y);
        z0 = '0;
        if (i_cmd.x < 0) begin
            if (i_cmd.y >= 0) begin
                x0 = XW'(i_cmd.y);
                y0 = -XW'(i_cmd.x);
                z0 = ZW'(HALF_PI_Q20);
            end else begin
                x0 = -XW'(i_cmd.y);
                y0 = XW'(i_cmd.x);
                z0 = -ZW'(HALF_PI_Q20);
            end
        end
        xs    = r_x >>> r_i;
        ys    = r_y >>> r_i;
        zabs  = r_z[ZW-1] ? -r_z : r_z;
        zr    = 35'(r_zm) + 35'(1 << 19);
        sv    = {r_ang, 3'b000} + 15'd5;
        sprod = 31'(sv) * 31'(RECIP10_Q19);
        dprod = 32'(r_dist[15:0]) * 32'(RECIP10_Q19);
        thr10 = {1'b0, i_cfg.max_speed_mm_s, 3'b000} + {3'b000, i_cfg.max_speed_mm_s, 1'b0};
        steer = (r_ang > i_cfg.heading_deadband_mrad) ? sprod[30:19] : 12'd0;
        rate  = r_zneg ? -$signed({1'b0, steer}) : $signed({1'b0, steer});
        if (r_dist <= 26'(i_cfg.stop_distance_mm)) begin
            speed = 12'd0;
        end else if (r_dist >= 26'(thr10)) begin
            speed = i_cfg.max_speed_mm_s;
        end else begin
            speed = dprod[30:19];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.avoid) begin
                            r_speed     <= 12'd0;
                            r_rate      <= i_cmd.turn_neg
                                           ? -$signed({1'b0, i_cfg.turn_rate_mrad_s})
                                           : $signed({1'b0, i_cfg.turn_rate_mrad_s});
                            r_avoid     <= 1'b1;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_x      <= x0;
                            r_y      <= y0;
                            r_z      <= z0;
                            r_i      <= '0;
                            r_origin <= (i_cmd.x == 0) && (i_cmd.y == 0);
                            r_state  <= S_ITER;
                        end
                    end
                end
                S_ITER: begin
                    if (r_y > 0) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + ZW'(atan_q20(r_i));
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - ZW'(atan_q20(r_i));
                    end
                    r_i <= r_i + STEP_W'(1);
                    if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 43'(r_x[XW-2:0]) * 43'(GAIN_Q16) + 43'(32768);
                    r_zm    <= 34'(zabs[ZW-2:0]) * 34'(1000);
                    r_zneg  <= r_z[ZW-1];
                    r_state <= S_POLAR;
                end
                S_POLAR: begin
                    r_dist  <= r_origin ? 26'd0 : r_prod[41:16];
                    r_ang   <= r_origin ? 12'd0 : zr[31:20];
                    r_state <= S_CMD;
                end
                S_CMD: begin
                    r_speed     <= speed;
                    r_rate      <= rate;
                    r_avoid     <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending during CORDIC pass");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_avoid) |-> (r_speed == 12'd0))
        else $error("avoid command with nonzero speed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER) |=> (r_state == S_ITER || r_state == S_MUL))
        else $error("CORDIC pass left early");
endmodule

/* rtl/follow_and_avoid_controller.sv */
// Top level: configuration registers, front end, command queue and back end.
// A scan sample takes effect in the cycle after acceptance. Follow ticks go from the
// queue through S_ITER, S_MUL, S_POLAR and S_CMD to the result register, avoid ticks
// straight to it; no command is popped during a CORDIC pass or while a result waits.
// Scan samples and avoid ticks are taken every cycle while the queue has room.
// Reset (synchronous, active low): registers to defaults, flags cleared, queue empty.
`timescale 1ns / 1ps
module follow_and_avoid_controller
    import fac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    fac_in_if.sink      i_item,
    fac_out_if.source   o_result
);
    t_cfg r_cfg;
    logic push, pop, full, empty;
    t_cmd push_cmd, pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ranges_per_scan       <= 13'd360;
            r_cfg.obstacle_threshold_mm <= 16'd500;
            r_cfg.stop_distance_mm      <= 16'd500;
            r_cfg.max_speed_mm_s        <= 12'd300;
            r_cfg.turn_rate_mrad_s      <= 12'd800;
            r_cfg.heading_deadband_mrad <= 12'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RANGES_PER_SCAN: r_cfg.ranges_per_scan       <= i_cfg_data[12:0];
                REG_OBST_THRESHOLD:  r_cfg.obstacle_threshold_mm <= i_cfg_data;
                REG_STOP_DISTANCE:   r_cfg.stop_distance_mm      <= i_cfg_data;
                REG_MAX_SPEED:       r_cfg.max_speed_mm_s        <= i_cfg_data[11:0];
                REG_TURN_RATE:       r_cfg.turn_rate_mrad_s      <= i_cfg_data[11:0];
                REG_DEADBAND:        r_cfg.heading_deadband_mrad <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    fac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    fac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (pop_cmd)
    );

    fac_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_cmd    (pop_cmd),
        .o_pop    (pop),
        .o_result (o_result)
    );
endmodule

/* sim/tb_top.sv */
// Testbench: random and directed items against a behavioral predictor of the controller.
`timescale 1ns / 1ps
module tb_top;
    import fac_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;

    typedef struct {
        logic               mode;
        logic [11:0]        idx;
        logic [15:0]        rng;
        logic               rvalid;
        logic               known;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               rbit;
    } t_item;

    typedef struct {
        logic [11:0]        speed;
        logic signed [12:0] rate;
        logic               avoid;
    } t_cmd_exp;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [15:0] i_cfg_data;

    fac_in_if  in_ch();
    fac_out_if out_ch();

    follow_and_avoid_controller u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_item(in_ch.sink), .o_result(out_ch.source)
    );

    t_item    pending_items[$];
    t_cmd_exp cmd_queue[$];
    int  errors = 0;
    int  quiet_cycles = 0;
    bit  calm = 0;
    bit  hold_sink = 0;
    bit  pause_src = 0;

    // predictor state and configuration
    logic [12:0] p_n;
    logic [15:0] p_thresh, p_stop;
    logic [11:0] p_vmax, p_turn, p_dead;
    bit p_hit, p_obst, p_turning, p_neg;

    int atan_tab[16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                         4096, 2048, 1024, 512, 256, 128, 64, 32};

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic predict_cmd(input t_item it);
        longint n, f, x, y, z, t, xs, ys, dist_mm, ang, p, a, r, speed, rate;
        t_cmd_exp e;
        speed = 0;
        rate = 0;
        if (!it.mode) begin
            n = (p_n > MAX_RANGES) ? MAX_RANGES : p_n;
            if (it.idx >= n) return;
            f = n / 12;
            if (it.idx == 0) p_hit = 0;
            if (it.rvalid && (it.idx <= f || it.idx >= n - f) && it.rng < p_thresh)
                p_hit = 1;
            if (it.idx == n - 1) p_obst = p_hit;
            return;
        end
        if (p_obst) begin
            if (!p_turning) begin
                p_neg = it.rbit;
                p_turning = 1;
            end
            rate = p_neg ? -longint'(p_turn) : longint'(p_turn);
            e.avoid = 1;
        end else begin
            p_turning = 0;
            if (!it.known) return;
            x = it.x;
            y = it.y;
            z = 0;
            if (x == 0 && y == 0) begin
                dist_mm = 0;
                ang = 0;
            end else begin
                if (x < 0) begin
                    t = x;
                    if (y >= 0) begin
                        x = y; y = -t; z = HALF_PI_Q20;
                    end else begin
                        x = -y; y = t; z = -HALF_PI_Q20;
                    end
                end
                for (int i = 0; i < CORDIC_STEPS; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y > 0) begin
                        x += ys; y -= xs; z += atan_tab[i];
                    end else begin
                        x -= ys; y += xs; z -= atan_tab[i];
                    end
                end
                dist_mm = (x * GAIN_Q16 + 32768) >>> 16;
                p = z * 1000;
                ang = (p < 0) ? -(((-p) + (1 << 19)) >>> 20) : ((p + (1 << 19)) >>> 20);
            end
            a = (ang < 0) ? -ang : ang;
            if (a > p_dead) begin
                r = (8 * a + 5) / 10;
                rate = (ang < 0) ? -r : r;
            end
            if (dist_mm > p_stop) begin
                speed = dist_mm / 10;
                if (speed > p_vmax) speed = p_vmax;
            end
            e.avoid = 0;
        end
        if (rate > 4095) rate = 4095;
        if (rate < -4096) rate = -4096;
        e.speed = speed[11:0];
        e.rate = rate[12:0];
        cmd_queue.push_back(e);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 0;
            in_ch.mode <= 0;
            in_ch.sample_index <= '0;
            in_ch.range_mm <= '0;
            in_ch.range_valid <= 0;
            in_ch.leader_known <= 0;
            in_ch.leader_x_mm <= '0;
            in_ch.leader_y_mm <= '0;
            in_ch.random_bit <= 0;
            out_ch.ready <= 0;
        end else begin
            if (pending_items.size() > 0 && !pause_src && (calm || $urandom_range(99) >= 15)) begin
                in_ch.valid <= 1;
                in_ch.mode <= pending_items[0].mode;
                in_ch.sample_index <= pending_items[0].idx;
                in_ch.range_mm <= pending_items[0].rng;
                in_ch.range_valid <= pending_items[0].rvalid;
                in_ch.leader_known <= pending_items[0].known;
                in_ch.leader_x_mm <= pending_items[0].x;
                in_ch.leader_y_mm <= pending_items[0].y;
                in_ch.random_bit <= pending_items[0].rbit;
            end else begin
                in_ch.valid <= 0;
            end
            out_ch.ready <= !hold_sink && (calm || $urandom_range(99) >= 15);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cmd_exp e;
        if (i_rst_n) begin
            quiet_cycles++;
            if (in_ch.valid && in_ch.ready) begin
                predict_cmd(pending_items.pop_front());
                quiet_cycles = 0;
            end
            if (out_ch.valid && out_ch.ready) begin
                quiet_cycles = 0;
                if (cmd_queue.size() == 0) begin
                    $error("unexpected result");
                    errors++;
                end else begin
                    e = cmd_queue.pop_front();
                    if (out_ch.linear_speed_mm_s !== e.speed) begin
                        $error("linear_speed_mm_s exp %0d got %0d", e.speed,
                               out_ch.linear_speed_mm_s);
                        errors++;
                    end
                    if (out_ch.angular_rate_mrad_s !== e.rate) begin
                        $error("angular_rate_mrad_s exp %0d got %0d", e.rate,
                               out_ch.angular_rate_mrad_s);
                        errors++;
                    end
                    if (out_ch.avoiding !== e.avoid) begin
                        $error("avoiding exp %0d got %0d", e.avoid, out_ch.avoiding);
                        errors++;
                    end
                end
            end
            if (quiet_cycles > 20000) begin
                $display("FAIL follow_and_avoid_controller");
                $finish;
            end
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_RANGES_PER_SCAN: p_n = val[12:0];
            REG_OBST_THRESHOLD:  p_thresh = val;
            REG_STOP_DISTANCE:   p_stop = val;
            REG_MAX_SPEED:       p_vmax = val[11:0];
            REG_TURN_RATE:       p_turn = val[11:0];
            REG_DEADBAND:        p_dead = val[11:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || cmd_queue.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_item tick_item(input bit known, input int x, input int y);
        t_item it;
        it.mode = 1;
        it.idx = 12'($urandom);
        it.rng = 16'($urandom);
        it.rvalid = 1'($urandom);
        it.known = known;
        it.x = 24'(x);
        it.y = 24'(y);
        it.rbit = 1'($urandom);
        return it;
    endfunction

    function automatic t_item scan_item(input int idx, input int rng, input bit v);
        t_item it;
        it = tick_item(1'($urandom), $urandom, $urandom);
        it.mode = 0;
        it.idx = 12'(idx);
        it.rng = 16'(rng);
        it.rvalid = v;
        return it;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(3))
            0: return int'($signed(24'($urandom)));
            1: return $urandom_range(6000) - 3000;
            2: return $urandom_range(200) - 100;
            default: return ($urandom_range(1) ? 8388607 : -8388608);
        endcase
    endfunction

    task automatic push_scan(input int n, input int obst_pct);
        for (int k = 0; k < n; k++)
            pending_items.push_back(scan_item(k, ($urandom_range(99) < obst_pct) ?
                                    $urandom_range(p_thresh) : $urandom, $urandom_range(9) > 0));
    endtask

    task automatic random_phase(input int count);
        int cnt;
        cnt = 0;
        while (cnt < count) begin
            case ($urandom_range(9))
                0, 1: begin
                    push_scan(p_n > 64 ? 64 : p_n, $urandom_range(1) ? 0 : 5);
                    cnt += (p_n > 64 ? 64 : p_n);
                end
                2: begin
                    pending_items.push_back(scan_item($urandom, $urandom, 1'($urandom)));
                    cnt++;
                end
                default: begin
                    pending_items.push_back(tick_item($urandom_range(9) > 0, rand_coord(),
                                                      rand_coord()));
                    cnt++;
                end
            endcase
        end
    endtask

    initial begin
        i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        i_rst_n = 0;
        p_n = 360; p_thresh = 500; p_stop = 500; p_vmax = 300; p_turn = 800; p_dead = 100;
        p_hit = 0; p_obst = 0; p_turning = 0; p_neg = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: small scan, obstacle edges, leader extremes
        cfg_write(REG_RANGES_PER_SCAN, 16'd12);
        cfg_write(REG_NONE, 16'hFFFF);
        pending_items.push_back(tick_item(1'b1, 0, 0));
        pending_items.push_back(tick_item(1'b1, 8388607, 0));
        pending_items.push_back(tick_item(1'b1, -8388608, -8388608));
        pending_items.push_back(tick_item(1'b1, -1000, 1));
        pending_items.push_back(tick_item(1'b1, 300, -600));
        pending_items.push_back(tick_item(1'b0, 5, 5));
        pending_items.push_back(scan_item(0, 0, 1'b1));
        pending_items.push_back(scan_item(5, 0, 1'b1));
        pending_items.push_back(scan_item(11, 499, 1'b1));
        pending_items.push_back(tick_item(1'b1, 1, 1));
        pending_items.push_back(tick_item(1'b0, 1, 1));
        pending_items.push_back(scan_item(0, 65535, 1'b0));
        pending_items.push_back(scan_item(11, 500, 1'b1));
        pending_items.push_back(scan_item(4095, 0, 1'b1));
        pending_items.push_back(tick_item(1'b1, 2000, 2000));
        drain();

        calm = 1;
        random_phase(150);
        drain();
        calm = 0;

        // long receiver hold while the sender keeps going
        hold_sink = 1;
        random_phase(100);
        repeat (400) @(posedge i_clk);
        hold_sink = 0;
        drain();

        cfg_write(REG_RANGES_PER_SCAN, 16'h1FFF);
        cfg_write(REG_OBST_THRESHOLD, 16'hFFFF);
        cfg_write(REG_STOP_DISTANCE, 16'd0);
        cfg_write(REG_MAX_SPEED, 16'd4095);
        cfg_write(REG_TURN_RATE, 16'd4095);
        cfg_write(REG_DEADBAND, 16'd0);
        random_phase(150);
        drain();

        cfg_write(REG_RANGES_PER_SCAN, 16'd0);
        cfg_write(REG_OBST_THRESHOLD, 16'd0);
        cfg_write(REG_STOP_DISTANCE, 16'hFFFF);
        cfg_write(REG_MAX_SPEED, 16'd0);
        cfg_write(REG_TURN_RATE, 16'd0);
        cfg_write(REG_DEADBAND, 16'd3142);
        random_phase(150);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(REG_RANGES_PER_SCAN, 16'($urandom_range(12, 40)));
            cfg_write(REG_OBST_THRESHOLD, 16'($urandom));
            cfg_write(REG_STOP_DISTANCE, 16'($urandom_range(2000)));
            cfg_write(REG_MAX_SPEED, 16'($urandom_range(4095)));
            cfg_write(REG_TURN_RATE, 16'($urandom_range(4095)));
            cfg_write(REG_DEADBAND, 16'($urandom_range(3142)));
            random_phase(180);
            pause_src = 1;
            while (cmd_queue.size() > 0 || in_ch.valid) @(posedge i_clk);
            pause_src = 0;
            drain();
        end

        if (errors == 0)
            $display("PASS follow_and_avoid_controller");
        else
            $display("FAIL follow_and_avoid_controller");
        $finish;
    end
endmodule

/* filelist.f */
rtl/fac_pkg.sv
rtl/fac_in_if.sv
rtl/fac_out_if.sv
rtl/fac_front.sv
rtl/fac_queue.sv
rtl/fac_back.sv
rtl/follow_and_avoid_controller.sv
sim/tb_top.sv
